// ===== hw/rtl/assert_macros.svh =====
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/pmsp_pkg.sv =====
package pmsp_pkg;

    localparam int CH_W        = 8;
    localparam int RIGHTS_W    = 9;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RIGHTS_W-1:0] RIGHTS_ALL = 9'o777;
    localparam logic [RIGHTS_W-1:0] PERM_R     = 9'o444;
    localparam logic [RIGHTS_W-1:0] PERM_W     = 9'o222;
    localparam logic [RIGHTS_W-1:0] PERM_X     = 9'o111;
    localparam logic [RIGHTS_W-1:0] CLASS_U    = 9'o700;
    localparam logic [RIGHTS_W-1:0] CLASS_G    = 9'o070;
    localparam logic [RIGHTS_W-1:0] CLASS_O    = 9'o007;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SUB  = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

    // one classified character
    typedef struct packed {
        logic                first;
        logic [RIGHTS_W-1:0] start_rights;
        logic                is_nul;
        logic                is_octal;
        logic [2:0]          digit;
        logic [RIGHTS_W-1:0] class_mask;
        logic [1:0]          op;
        logic [RIGHTS_W-1:0] perm_mask;
        logic                is_comma;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== hw/rtl/pmsp_front.sv =====
module pmsp_front (
    input  logic [pmsp_pkg::CH_W-1:0]     i_ch,
    input  logic                          i_first,
    input  logic [pmsp_pkg::RIGHTS_W-1:0] i_start_rights,
    output pmsp_pkg::t_item               o_item
);

    function automatic logic [pmsp_pkg::RIGHTS_W-1:0] class_of(input logic [7:0] c);
        logic [pmsp_pkg::RIGHTS_W-1:0] m;
        begin
            m = '0;
            if (c == 8'h75) m = pmsp_pkg::CLASS_U;
            if (c == 8'h67) m = pmsp_pkg::CLASS_G;
            if (c == 8'h6f) m = pmsp_pkg::CLASS_O;
            if (c == 8'h61) m = pmsp_pkg::RIGHTS_ALL;
            return m;
        end
    endfunction

    function automatic logic [pmsp_pkg::RIGHTS_W-1:0] perm_of(input logic [7:0] c);
        logic [pmsp_pkg::RIGHTS_W-1:0] m;
        begin
            m = '0;
            if (c == 8'h72) m = pmsp_pkg::PERM_R;
            if (c == 8'h77) m = pmsp_pkg::PERM_W;
            if (c == 8'h78) m = pmsp_pkg::PERM_X;
            return m;
        end
    endfunction

    function automatic logic [1:0] op_of(input logic [7:0] c);
        logic [1:0] o;
        begin
            o = pmsp_pkg::OP_NONE;
            if (c == 8'h2b) o = pmsp_pkg::OP_ADD;
            if (c == 8'h2d) o = pmsp_pkg::OP_SUB;
            if (c == 8'h3d) o = pmsp_pkg::OP_SET;
            return o;
        end
    endfunction

    always_comb begin
        o_item.first        = i_first;
        o_item.start_rights = i_start_rights;
        o_item.is_nul       = (i_ch == 8'h00);
        // '0' through '7'
        o_item.is_octal     = (i_ch[7:3] == 5'b00110);
        o_item.digit        = i_ch[2:0];
        o_item.class_mask   = class_of(i_ch);
        o_item.op           = op_of(i_ch);
        o_item.perm_mask    = perm_of(i_ch);
        o_item.is_comma     = (i_ch == 8'h2c);
    end

endmodule

// ===== hw/rtl/pmsp_queue.sv =====
module pmsp_queue #(
    parameter int DEPTH = pmsp_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pmsp_pkg::t_item   i_item,
    input  logic              i_pop,
    output pmsp_pkg::t_q_head o_head,
    output pmsp_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pmsp_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    assign o_head.valid = !o_stat.empty;
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_count = r_count + CNT_W'(w_push) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/pmsp_back.sv =====
module pmsp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pmsp_pkg::t_q_head             i_head,
    output logic                          o_pop,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [pmsp_pkg::RIGHTS_W-1:0] o_rights,
    output logic [pmsp_pkg::STATUS_W-1:0] o_status
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_DIGIT = 3'd1;
    localparam logic [2:0] PH_WHO   = 3'd2;
    localparam logic [2:0] PH_PERM  = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;

    localparam int RW = pmsp_pkg::RIGHTS_W;

    logic [2:0]    r_phase, n_phase;
    logic [RW-1:0] r_work, n_work;
    logic [RW-1:0] r_saved, n_saved;
    logic [RW-1:0] r_who, n_who;
    logic [RW-1:0] r_perm, n_perm;
    logic [1:0]    r_op, n_op;
    logic [1:0]    r_weight, n_weight;
    logic          r_err, n_err;

    logic                          r_out_valid;
    logic [RW-1:0]                 r_out_rights;
    logic [pmsp_pkg::STATUS_W-1:0] r_out_status;

    logic                          w_emit;
    logic [RW-1:0]                 w_res_rights;
    logic [pmsp_pkg::STATUS_W-1:0] w_res_status;

    pmsp_pkg::t_item w_it;

    assign w_it  = i_head.item;
    assign o_pop = i_head.valid && (!r_out_valid || i_out_ready);

    always_comb begin
        logic          run;
        logic [RW-1:0] sel;
        n_phase      = r_phase;
        n_work       = r_work;
        n_saved      = r_saved;
        n_who        = r_who;
        n_perm       = r_perm;
        n_op         = r_op;
        n_weight     = r_weight;
        n_err        = r_err;
        w_emit       = 1'b0;
        w_res_rights = r_work;
        w_res_status = pmsp_pkg::ST_OK;
        run          = 1'b1;
        sel          = '0;

        if (w_it.first) begin
            n_saved  = w_it.start_rights;
            n_work   = w_it.start_rights;
            n_who    = '0;
            n_perm   = '0;
            n_op     = pmsp_pkg::OP_ADD;
            n_weight = 2'd0;
            n_err    = 1'b0;
            run      = 1'b0;
            if (w_it.is_nul) begin
                w_emit       = 1'b1;
                w_res_rights = w_it.start_rights;
                w_res_status = pmsp_pkg::ST_EMPTY;
                n_phase      = PH_IDLE;
            end else if (w_it.is_octal) begin
                n_work   = {w_it.digit, 6'b000000};
                n_weight = 2'd1;
                n_phase  = PH_DIGIT;
            end else if (w_it.class_mask == '0 && w_it.op == pmsp_pkg::OP_NONE) begin
                n_err   = 1'b1;
                n_phase = PH_SKIP;
            end else begin
                n_phase = PH_WHO;
                run     = 1'b1;
            end
        end

        if (run) begin
            unique case (n_phase)
                PH_DIGIT: begin
                    if (w_it.is_nul) begin
                        w_emit = 1'b1;
                    end else if (!w_it.is_octal) begin
                        n_err   = 1'b1;
                        n_phase = PH_SKIP;
                    end else if (n_weight == 2'd1) begin
                        n_work   = n_work | {3'b000, w_it.digit, 3'b000};
                        n_weight = 2'd2;
                    end else begin
                        n_work  = n_work | {6'b000000, w_it.digit};
                        n_phase = PH_SKIP;
                    end
                end
                PH_WHO: begin
                    if (w_it.class_mask != '0) begin
                        n_who = n_who | w_it.class_mask;
                    end else if (w_it.op != pmsp_pkg::OP_NONE) begin
                        n_op    = w_it.op;
                        n_who   = (n_who == '0) ? pmsp_pkg::RIGHTS_ALL : n_who;
                        n_perm  = '0;
                        n_phase = PH_PERM;
                    end else if (w_it.is_nul && n_who == '0) begin
                        // nul right after a comma closes the command cleanly
                        w_emit = 1'b1;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = PH_SKIP;
                        w_emit  = w_it.is_nul;
                    end
                end
                PH_PERM: begin
                    if (w_it.perm_mask != '0) begin
                        n_perm = n_perm | w_it.perm_mask;
                    end else begin
                        sel = n_perm & n_who;
                        unique case (n_op)
                            pmsp_pkg::OP_ADD: n_work = n_work | sel;
                            pmsp_pkg::OP_SUB: n_work = n_work & ~sel;
                            default:          n_work = (n_work & ~n_who) | sel;
                        endcase
                        if (w_it.is_comma) begin
                            n_who   = '0;
                            n_phase = PH_WHO;
                        end else if (w_it.is_nul) begin
                            w_emit = 1'b1;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    w_emit = w_it.is_nul;
                end
                default: begin
                end
            endcase
            if (w_emit) begin
                w_res_rights = n_err ? n_saved : n_work;
                w_res_status = n_err ? pmsp_pkg::ST_ERROR : pmsp_pkg::ST_OK;
                n_phase      = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_work      <= '0;
            r_saved     <= '0;
            r_who       <= '0;
            r_perm      <= '0;
            r_op        <= pmsp_pkg::OP_ADD;
            r_weight    <= 2'd0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase  <= n_phase;
                r_work   <= n_work;
                r_saved  <= n_saved;
                r_who    <= n_who;
                r_perm   <= n_perm;
                r_op     <= n_op;
                r_weight <= n_weight;
                r_err    <= n_err;
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_out_rights <= w_res_rights;
            r_out_status <= w_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rights    = r_out_rights;
    assign o_status    = r_out_status;

endmodule

// ===== hw/rtl/permission_mode_string_parser.sv =====
// path: an accepted terminating nul beat is written into the queue, then its result is registered onto m_axis,
// when the queue is empty and no earlier result is waiting
// throughput: one character beat per cycle while m_axis takes results; a waiting result stalls the parser
// a 2-entry queue (QUEUE_DEPTH) absorbs up to 2 beats while a result waits on m_axis
// reset: synchronous, active low; empties the queue, idles the parser, drops m_axis_tvalid
`include "assert_macros.svh"

module permission_mode_string_parser #(
    parameter int QUEUE_DEPTH = pmsp_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // ch [7:0], start_rights [16:8], zero pad [23:17]
    input  logic [pmsp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // first [0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // rights [8:0], status [10:9], zero pad [15:11]
    output logic [pmsp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int CW    = pmsp_pkg::CH_W;
    localparam int RW    = pmsp_pkg::RIGHTS_W;
    localparam int SW    = pmsp_pkg::STATUS_W;
    localparam int M_PAD = pmsp_pkg::M_TDATA_W - RW - SW;

    pmsp_pkg::t_item   w_item;
    pmsp_pkg::t_q_head w_head;
    pmsp_pkg::t_q_stat w_stat;
    logic              w_pop;
    logic [RW-1:0]     w_rights;
    logic [SW-1:0]     w_status;

    pmsp_front u_front (
        .i_ch           (s_axis_tdata[CW-1:0]),
        .i_first        (s_axis_tuser),
        .i_start_rights (s_axis_tdata[CW+RW-1:CW]),
        .o_item         (w_item)
    );

    pmsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    pmsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_rights    (w_rights),
        .o_status    (w_status)
    );

    assign s_axis_tready = !w_stat.full;
    assign m_axis_tdata  = {{M_PAD{1'b0}}, w_status, w_rights};

    `ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, w_pop, !w_stat.empty)
    `ASSERT_IMPLIES(a_full_xor_empty, i_clk, i_rst_n, w_stat.full, !w_stat.empty)
    `ASSERT_IMPLIES(a_status_legal, i_clk, i_rst_n, m_axis_tvalid, w_status <= pmsp_pkg::ST_ERROR)
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !w_pop, !w_stat.empty)

endmodule
